[rtl/core/pkiu_pkg.sv]
// Shared types, constants and helper functions for the packed index word unpacker.
package pkiu_pkg;

    localparam int WORD_W          = 64;
    localparam int PSIZE_W         = 13;
    localparam int POS_W           = 12;
    localparam int IDX_W           = 12;
    localparam int DONE_W          = 13;
    localparam int FBITS_W         = 4;
    localparam int NFLD_W          = 5;
    localparam int MIN_FIELD_BITS  = 4;
    localparam int MAX_FIELDS      = 16;
    localparam int SECTION_ENTRIES = 4096;

    // Whole fields in one word for every field width, indexed by the width.
    localparam logic [15:0][7:0] FIELDS_IN_WORD = {
        8'(WORD_W / 15), 8'(WORD_W / 14), 8'(WORD_W / 13), 8'(WORD_W / 12),
        8'(WORD_W / 11), 8'(WORD_W / 10), 8'(WORD_W / 9),  8'(WORD_W / 8),
        8'(WORD_W / 7),  8'(WORD_W / 6),  8'(WORD_W / 5),  8'(WORD_W / 4),
        8'(WORD_W / 3),  8'(WORD_W / 2),  8'(WORD_W / 1),  8'd0
    };

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              first_word;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] entry_position;
        logic [IDX_W-1:0] palette_index;
        logic             last_of_word;
    } t_out_item;

    typedef struct packed {
        logic [WORD_W-1:0]  data_word;
        logic               first_word;
        logic [FBITS_W-1:0] fbits;
        logic [NFLD_W-1:0]  nfields;
    } t_q_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // Field width: bit length of (palette size - 1), never below the minimum.
    function automatic logic [FBITS_W-1:0] field_bits(logic [PSIZE_W-1:0] psize);
        logic [PSIZE_W-1:0] s;
        logic [FBITS_W-1:0] len;
        s   = (psize == '0) ? '0 : psize - PSIZE_W'(1);
        len = FBITS_W'(MIN_FIELD_BITS);
        for (int i = 0; i < PSIZE_W; i++) begin
            if (s[i] && (i + 1 > MIN_FIELD_BITS)) begin
                len = FBITS_W'(i + 1);
            end
        end
        return len;
    endfunction

    // Whole fields in one word, capped at the number a word may emit.
    function automatic logic [NFLD_W-1:0] fields_per_word(logic [FBITS_W-1:0] fbits);
        logic [7:0]        f;
        logic [NFLD_W-1:0] n;
        f = FIELDS_IN_WORD[fbits];
        n = (f > 8'(MAX_FIELDS)) ? NFLD_W'(MAX_FIELDS) : NFLD_W'(f);
        return n;
    endfunction

    function automatic logic [IDX_W-1:0] field_mask(logic [FBITS_W-1:0] fbits);
        logic [IDX_W-1:0] m;
        for (int i = 0; i < IDX_W; i++) begin
            m[i] = (i < int'(fbits));
        end
        return m;
    endfunction

endpackage

[rtl/core/pkiu_front.sv]
// Front end: holds the palette size register and classifies each accepted word.
module pkiu_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pkiu_pkg::PSIZE_W-1:0]     i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  pkiu_pkg::t_in_item               i_in_item,
    input  pkiu_pkg::t_q_stat                i_q_stat,
    output logic                             o_push,
    output pkiu_pkg::t_q_entry               o_push_entry
);

    logic [pkiu_pkg::PSIZE_W-1:0] r_palette_size;
    logic [pkiu_pkg::FBITS_W-1:0] fbits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= pkiu_pkg::PSIZE_W'(1);
        end else if (i_cfg_we) begin
            r_palette_size <= i_cfg_wdata;
        end
    end

    assign fbits      = pkiu_pkg::field_bits(r_palette_size);
    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_push_entry.data_word  = i_in_item.data_word;
        o_push_entry.first_word = i_in_item.first_word;
        o_push_entry.fbits      = fbits;
        o_push_entry.nfields    = pkiu_pkg::fields_per_word(fbits);
    end

endmodule

[rtl/core/pkiu_queue.sv]
// Two-entry queue of classified words between the front and back ends.
module pkiu_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pkiu_pkg::t_q_entry i_push_entry,
    input  logic               i_pop,
    output pkiu_pkg::t_q_entry o_head,
    output pkiu_pkg::t_q_stat  o_stat
);

    pkiu_pkg::t_q_entry r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_entry;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

endmodule

[rtl/core/pkiu_back.sv]
// Back end: cuts a word into fields, one a cycle unless stalled; tracks the section position.
module pkiu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pkiu_pkg::t_q_entry  i_head,
    input  pkiu_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pkiu_pkg::t_out_item o_out_item
);

    logic                          r_busy;
    logic                          n_busy;
    logic [pkiu_pkg::WORD_W-1:0]   r_word;
    logic [pkiu_pkg::WORD_W-1:0]   n_word;
    logic [pkiu_pkg::FBITS_W-1:0]  r_fbits;
    logic [pkiu_pkg::FBITS_W-1:0]  n_fbits;
    logic [pkiu_pkg::NFLD_W-1:0]   r_left;
    logic [pkiu_pkg::NFLD_W-1:0]   n_left;
    logic [pkiu_pkg::DONE_W-1:0]   r_done;
    logic [pkiu_pkg::DONE_W-1:0]   n_done;
    logic                          r_out_valid;
    logic                          n_out_valid;
    pkiu_pkg::t_out_item           r_out_item;
    pkiu_pkg::t_out_item           n_out_item;
    logic                          emit;
    logic                          fld_last;

    assign emit     = r_busy && (!r_out_valid || i_out_ready);
    assign fld_last = (r_left == pkiu_pkg::NFLD_W'(1))
                   || (r_done == pkiu_pkg::DONE_W'(pkiu_pkg::SECTION_ENTRIES - 1));
    assign o_pop    = !i_q_stat.empty && (!r_busy || (emit && fld_last));

    always_comb begin
        n_busy      = r_busy;
        n_word      = r_word;
        n_fbits     = r_fbits;
        n_left      = r_left;
        n_done      = r_done;
        n_out_item  = r_out_item;
        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;
        if (emit) begin
            n_out_valid                = 1'b1;
            n_out_item.entry_position  = r_done[pkiu_pkg::POS_W-1:0];
            n_out_item.palette_index   = r_word[pkiu_pkg::IDX_W-1:0]
                                       & pkiu_pkg::field_mask(r_fbits);
            n_out_item.last_of_word    = fld_last;
            n_done                     = r_done + pkiu_pkg::DONE_W'(1);
            n_word                     = r_word >> r_fbits;
            n_left                     = r_left - pkiu_pkg::NFLD_W'(1);
            if (fld_last) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            if (i_head.first_word) begin
                n_done = '0;
            end
            // A full section without a restart drops the word.
            n_busy  = (n_done < pkiu_pkg::DONE_W'(pkiu_pkg::SECTION_ENTRIES));
            n_word  = i_head.data_word;
            n_fbits = i_head.fbits;
            n_left  = i_head.nfields;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_fbits    <= n_fbits;
        r_left     <= n_left;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[rtl/core/packed_index_word_unpacker.sv]
// A word goes through a queue entry and the back end word register; each result is then registered.
// The back end emits one result per cycle while the output is not stalled, one per field of the
// word (4 to 16, 16 with 4-bit fields) unless the section fills first.
// The two-entry queue lets the next words be accepted while the back end is still unpacking.
// Reset (synchronous, active low) empties the queue, clears the position and sets palette size 1.
module packed_index_word_unpacker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pkiu_pkg::PSIZE_W-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pkiu_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pkiu_pkg::t_out_item           o_out_item
);

    // Handshake and status between the three parts.
    logic               push;
    logic               pop;
    pkiu_pkg::t_q_entry push_entry;
    pkiu_pkg::t_q_entry head;
    pkiu_pkg::t_q_stat  q_stat;

    // The front end owns the palette size register. It works out the field
    // width and the number of fields per word for every accepted item, so
    // the back end never has to look at the configuration.
    pkiu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    // The queue decouples input acceptance from the field-by-field unpacking.
    pkiu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_stat       (q_stat)
    );

    // The back end shifts the word down one field per cycle while the output is not
    // stalled and keeps the running section position. It loads the next word in the
    // same cycle as the final field of the current one, so queued words follow without a gap.
    pkiu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // The output register is empty right after reset.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The entry that fills the section is always flagged as the last of its word.
    a_section_end_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.entry_position == pkiu_pkg::POS_W'(pkiu_pkg::SECTION_ENTRIES - 1))
        |-> o_out_item.last_of_word)
        else $error("section end without last flag");

    // The queue can never be full and empty at once.
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");

    // Nothing is popped from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule
